### src/sts_pkg.sv
// shared types and constants for the sorted table search unit
package sts_pkg;

  // default sizing of the table
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int VALUE_BITS_DEF  = 32;

  // fixed field widths
  localparam int COUNT_BITS = 11;
  localparam int POS_BITS   = 12;

  // request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // search modes
  typedef logic [2:0] mode_t;
  localparam mode_t MODE_EXACT = 3'd0;
  localparam mode_t MODE_LOWER = 3'd1;
  localparam mode_t MODE_UPPER = 3'd2;
  localparam mode_t MODE_FIRST = 3'd3;
  localparam mode_t MODE_LAST  = 3'd4;

  // control carried alongside each request through the pipeline
  typedef struct packed {
    logic  vld;
    logic  qry;
    logic  wr;
    mode_t mode;
  } ctrl_t;

endpackage

### src/sts_stage.sv
// one bisection level of the search pipeline with its own copy of the table
module sts_stage #(
  parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_BITS  = sts_pkg::VALUE_BITS_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    en,
  input  sts_pkg::ctrl_t                                          up_ctrl,
  input  logic signed [VALUE_BITS-1:0]                            up_key,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] up_widx,
  input  logic signed [VALUE_BITS-1:0]                            up_wval,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]                        up_n,
  input  logic signed [$clog2(TABLE_DEPTH+1):0]                   up_lo,
  input  logic signed [$clog2(TABLE_DEPTH+1):0]                   up_hi,
  input  logic                                                    up_found,
  input  logic signed [$clog2(TABLE_DEPTH+1):0]                   up_res,
  input  logic                                                    up_rd,
  input  logic signed [$clog2(TABLE_DEPTH+1):0]                   up_mid,
  input  logic signed [VALUE_BITS-1:0]                            up_data,
  output sts_pkg::ctrl_t                                          dn_ctrl,
  output logic signed [VALUE_BITS-1:0]                            dn_key,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] dn_widx,
  output logic signed [VALUE_BITS-1:0]                            dn_wval,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]                        dn_n,
  output logic signed [$clog2(TABLE_DEPTH+1):0]                   dn_lo,
  output logic signed [$clog2(TABLE_DEPTH+1):0]                   dn_hi,
  output logic                                                    dn_found,
  output logic signed [$clog2(TABLE_DEPTH+1):0]                   dn_res,
  output logic                                                    dn_rd,
  output logic signed [$clog2(TABLE_DEPTH+1):0]                   dn_mid,
  output logic signed [VALUE_BITS-1:0]                            dn_data
);
  import sts_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH+1);
  localparam int PW = CW + 1;

  logic signed [VALUE_BITS-1:0] mem [0:TABLE_DEPTH-1];

  logic                 exact;
  logic                 strict;
  logic                 go_right;
  logic signed [PW-1:0] lo_u;
  logic signed [PW-1:0] hi_u;
  logic                 found_u;
  logic signed [PW-1:0] res_u;
  logic signed [PW-1:0] diff;
  logic signed [PW-1:0] mid_next;
  logic                 active;

  // fold in the entry read by the previous level, then pick the next midpoint
  always_comb begin
    exact    = (up_ctrl.mode == MODE_EXACT);
    strict   = (up_ctrl.mode == MODE_UPPER) || (up_ctrl.mode == MODE_LAST);
    go_right = strict ? (up_data <= up_key) : (up_data < up_key);
    lo_u     = up_lo;
    hi_u     = up_hi;
    found_u  = up_found;
    res_u    = up_res;
    if (up_rd) begin
      if (exact) begin
        if (up_data == up_key) begin
          found_u = 1'b1;
          res_u   = up_mid;
        end else if (up_data < up_key) begin
          lo_u = up_mid + PW'(1);
        end else begin
          hi_u = up_mid - PW'(1);
        end
      end else if (go_right) begin
        lo_u = up_mid + PW'(1);
      end else begin
        hi_u = up_mid;
      end
    end
    diff     = hi_u - lo_u;
    mid_next = lo_u + (diff >>> 1);
    active   = up_ctrl.vld && up_ctrl.qry &&
               (exact ? (!found_u && (lo_u <= hi_u)) : (lo_u < hi_u));
  end

  // table copy: writes pass at this level, queries read the midpoint
  always_ff @(posedge clk) begin
    if (en) begin
      if (up_ctrl.wr) begin
        mem[up_widx] <= up_wval;
      end else if (active) begin
        dn_data <= mem[mid_next[IW-1:0]];
      end
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_ctrl <= '0;
    end else if (en) begin
      dn_ctrl <= up_ctrl;
    end
  end

  // search state registers
  always_ff @(posedge clk) begin
    if (en) begin
      dn_key   <= up_key;
      dn_widx  <= up_widx;
      dn_wval  <= up_wval;
      dn_n     <= up_n;
      dn_lo    <= lo_u;
      dn_hi    <= hi_u;
      dn_found <= found_u;
      dn_res   <= res_u;
      dn_rd    <= active;
      dn_mid   <= mid_next;
    end
  end

endmodule

### src/sts_check.sv
// result selection, equality check for first and last modes, output register
module sts_check #(
  parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_BITS  = sts_pkg::VALUE_BITS_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    en,
  input  sts_pkg::ctrl_t                                          up_ctrl,
  input  logic signed [VALUE_BITS-1:0]                            up_key,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] up_widx,
  input  logic signed [VALUE_BITS-1:0]                            up_wval,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]                        up_n,
  input  logic signed [$clog2(TABLE_DEPTH+1):0]                   up_lo,
  input  logic                                                    up_found,
  input  logic signed [$clog2(TABLE_DEPTH+1):0]                   up_res,
  output logic                                                    out_valid,
  output logic signed [sts_pkg::POS_BITS-1:0]                     position
);
  import sts_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH+1);
  localparam int PW = CW + 1;

  logic signed [VALUE_BITS-1:0] mem [0:TABLE_DEPTH-1];

  logic signed [PW-1:0]         pos_c;
  logic                         need_c;
  logic                         ok_c;
  logic signed [PW-1:0]         n_s;
  logic                         c_vld;
  logic signed [PW-1:0]         c_pos;
  logic                         c_need;
  logic                         c_ok;
  logic signed [VALUE_BITS-1:0] c_key;
  logic signed [VALUE_BITS-1:0] c_data;
  logic signed [PW-1:0]         pos_f;
  logic signed [POS_BITS-1:0]   pos_w;

  // candidate position per mode
  always_comb begin
    n_s    = {1'b0, up_n};
    pos_c  = '1;
    need_c = 1'b0;
    ok_c   = 1'b0;
    case (up_ctrl.mode)
      MODE_EXACT: pos_c = up_found ? up_res : '1;
      MODE_LOWER: pos_c = up_lo;
      MODE_UPPER: pos_c = up_lo;
      MODE_FIRST: begin
        pos_c  = up_lo;
        need_c = 1'b1;
        ok_c   = (up_lo < n_s);
      end
      MODE_LAST: begin
        pos_c  = up_lo - PW'(1);
        need_c = 1'b1;
        ok_c   = (up_lo > PW'(0));
      end
      default: pos_c = '1;
    endcase
  end

  // last table copy: writes pass here, first and last modes read the candidate
  always_ff @(posedge clk) begin
    if (en) begin
      if (up_ctrl.wr) begin
        mem[up_widx] <= up_wval;
      end else if (up_ctrl.vld && up_ctrl.qry && need_c && ok_c) begin
        c_data <= mem[pos_c[IW-1:0]];
      end
    end
  end

  // check stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= up_ctrl.vld && up_ctrl.qry;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_pos  <= pos_c;
      c_need <= need_c;
      c_ok   <= ok_c;
      c_key  <= up_key;
    end
  end

  // final position, fitted to the output field
  always_comb begin
    pos_f = c_pos;
    if (c_need && !(c_ok && (c_data == c_key))) begin
      pos_f = '1;
    end
  end

  generate
    if (PW >= POS_BITS) begin : g_trunc
      assign pos_w = pos_f[POS_BITS-1:0];
    end else begin : g_ext
      assign pos_w = {{(POS_BITS-PW){pos_f[PW-1]}}, pos_f};
    end
  endgenerate

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      position <= pos_w;
    end
  end

endmodule

### src/sorted_table_search_unit.sv
// Sorted table search unit: pipelined binary search over a replicated table.
// Requests pass one bisection level per step, each level reading its own table copy,
// then a check stage and the output register.
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// Write requests travel the pipeline and update each table copy at its own level.
// Reset (rst, synchronous) clears valid bits and table_count; table contents stay undefined.
module sorted_table_search_unit #(
  parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_BITS  = sts_pkg::VALUE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   table_count_valid,
  output logic                                   table_count_ready,
  input  logic [sts_pkg::COUNT_BITS-1:0]         table_count,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   opcode,
  input  logic [9:0]                             entry_index,
  input  logic signed [31:0]                     entry_value,
  input  logic signed [31:0]                     search_value,
  input  logic [2:0]                             search_mode,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [sts_pkg::POS_BITS-1:0]    position
);
  import sts_pkg::*;

  localparam int IW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW     = $clog2(TABLE_DEPTH+1);
  localparam int PW     = CW + 1;
  localparam int LEVELS = CW;

  logic [COUNT_BITS-1:0] cur_count;
  logic                  en;
  logic [CW-1:0]         n_used;
  logic [31:0]           eidx_w;

  ctrl_t                        ctrl_s  [0:LEVELS+1];
  logic signed [VALUE_BITS-1:0] key_s   [0:LEVELS+1];
  logic [IW-1:0]                widx_s  [0:LEVELS+1];
  logic signed [VALUE_BITS-1:0] wval_s  [0:LEVELS+1];
  logic [CW-1:0]                n_s     [0:LEVELS+1];
  logic signed [PW-1:0]         lo_s    [0:LEVELS+1];
  logic signed [PW-1:0]         hi_s    [0:LEVELS+1];
  logic                         found_s [0:LEVELS+1];
  logic signed [PW-1:0]         res_s   [0:LEVELS+1];
  logic                         rd_s    [0:LEVELS+1];
  logic signed [PW-1:0]         mid_s   [0:LEVELS+1];
  logic signed [VALUE_BITS-1:0] data_s  [0:LEVELS+1];

  // configuration register
  assign table_count_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_count <= '0;
    end else if (table_count_valid) begin
      cur_count <= table_count;
    end
  end

  // pipeline advances unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // entries in use, saturated at the depth
  assign n_used = (32'(cur_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cur_count);
  assign eidx_w = 32'(entry_index);

  // value width fitting
  generate
    if (VALUE_BITS <= 32) begin : g_val_narrow
      assign key_s[0]  = search_value[VALUE_BITS-1:0];
      assign wval_s[0] = entry_value[VALUE_BITS-1:0];
    end else begin : g_val_wide
      assign key_s[0]  = {{(VALUE_BITS-32){search_value[31]}}, search_value};
      assign wval_s[0] = {{(VALUE_BITS-32){entry_value[31]}}, entry_value};
    end
  endgenerate

  // request entering the first level
  always_comb begin
    ctrl_s[0].vld  = in_valid;
    ctrl_s[0].qry  = (opcode == OP_QUERY);
    ctrl_s[0].wr   = in_valid && (opcode == OP_WRITE) && (eidx_w < 32'(TABLE_DEPTH));
    ctrl_s[0].mode = search_mode;
    widx_s[0]      = eidx_w[IW-1:0];
    n_s[0]         = n_used;
    lo_s[0]        = '0;
    hi_s[0]        = (search_mode == MODE_EXACT) ? ({1'b0, n_used} - PW'(1)) : {1'b0, n_used};
    found_s[0]     = 1'b0;
    res_s[0]       = '1;
    rd_s[0]        = 1'b0;
    mid_s[0]       = '0;
    data_s[0]      = '0;
  end

  // bisection levels, the last one only folds in the final read
  generate
    for (genvar k = 0; k <= LEVELS; k++) begin : g_level
      sts_stage #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
      ) u_stage (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .up_ctrl  (ctrl_s[k]),
        .up_key   (key_s[k]),
        .up_widx  (widx_s[k]),
        .up_wval  (wval_s[k]),
        .up_n     (n_s[k]),
        .up_lo    (lo_s[k]),
        .up_hi    (hi_s[k]),
        .up_found (found_s[k]),
        .up_res   (res_s[k]),
        .up_rd    (rd_s[k]),
        .up_mid   (mid_s[k]),
        .up_data  (data_s[k]),
        .dn_ctrl  (ctrl_s[k+1]),
        .dn_key   (key_s[k+1]),
        .dn_widx  (widx_s[k+1]),
        .dn_wval  (wval_s[k+1]),
        .dn_n     (n_s[k+1]),
        .dn_lo    (lo_s[k+1]),
        .dn_hi    (hi_s[k+1]),
        .dn_found (found_s[k+1]),
        .dn_res   (res_s[k+1]),
        .dn_rd    (rd_s[k+1]),
        .dn_mid   (mid_s[k+1]),
        .dn_data  (data_s[k+1])
      );
    end
  endgenerate

  // result selection and output register
  sts_check #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .up_ctrl   (ctrl_s[LEVELS+1]),
    .up_key    (key_s[LEVELS+1]),
    .up_widx   (widx_s[LEVELS+1]),
    .up_wval   (wval_s[LEVELS+1]),
    .up_n      (n_s[LEVELS+1]),
    .up_lo     (lo_s[LEVELS+1]),
    .up_found  (found_s[LEVELS+1]),
    .up_res    (res_s[LEVELS+1]),
    .out_valid (out_valid),
    .position  (position)
  );

endmodule

### sim/sorted_table_search_unit_check.sv
// result checker for the sorted table search unit: mirrors the table and compares positions
module sorted_table_search_unit_check (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               table_count_valid,
  input  logic                               table_count_ready,
  input  logic [sts_pkg::COUNT_BITS-1:0]     table_count,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               opcode,
  input  logic [9:0]                         entry_index,
  input  logic signed [31:0]                 entry_value,
  input  logic signed [31:0]                 search_value,
  input  logic [2:0]                         search_mode,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [sts_pkg::POS_BITS-1:0] position,
  output int                                 errors,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sts_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  logic signed [31:0]         mirror_table [DEPTH];
  logic [COUNT_BITS-1:0]      mirror_count;
  logic signed [POS_BITS-1:0] expected_positions [$];

  // first index whose entry is above the key (strict) or not below it
  function automatic int bound_index(logic signed [31:0] key, bit strict, int n);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (strict ? (mirror_table[mid] <= key) : (mirror_table[mid] < key)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // position that a query should return
  function automatic logic signed [POS_BITS-1:0] search_position(logic signed [31:0] key,
                                                                 mode_t mode);
    int n;
    int lo;
    int hi;
    int mid;
    int pos;
    n = (mirror_count > DEPTH) ? DEPTH : int'(mirror_count);
    pos = -1;
    case (mode)
      MODE_EXACT: begin
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (mirror_table[mid] == key) begin
            pos = mid;
            break;
          end
          if (mirror_table[mid] < key) lo = mid + 1;
          else hi = mid - 1;
        end
      end
      MODE_LOWER: pos = bound_index(key, 1'b0, n);
      MODE_UPPER: pos = bound_index(key, 1'b1, n);
      MODE_FIRST: begin
        pos = bound_index(key, 1'b0, n);
        if (!(pos < n && mirror_table[pos] == key)) pos = -1;
      end
      MODE_LAST: begin
        pos = bound_index(key, 1'b1, n) - 1;
        if (!(pos >= 0 && pos < n && mirror_table[pos] == key)) pos = -1;
      end
      default: pos = -1;
    endcase
    return POS_BITS'(pos);
  endfunction

  assign pending = expected_positions.size();

  // track register writes, requests and results
  always @(posedge clk) begin
    logic signed [POS_BITS-1:0] want;
    if (rst) begin
      mirror_count <= '0;
      errors = 0;
      expected_positions.delete();
    end else begin
      if (table_count_valid && table_count_ready) mirror_count <= table_count;
      if (in_valid && !in_stall) begin
        if (opcode == OP_WRITE) mirror_table[entry_index] = entry_value;
        else expected_positions.push_back(search_position(search_value, mode_t'(search_mode)));
      end
      if (out_valid && !out_stall) begin
        if (expected_positions.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual position %0d",
                   $time, position);
        end else begin
          want = expected_positions.pop_front();
          if (position !== want) begin
            errors++;
            $display("%0t: position mismatch, expected %0d, actual %0d", $time, want, position);
          end
        end
      end
    end
  end

endmodule

### sim/sorted_table_search_unit_test.sv
// stimulus and verdict for the sorted table search unit
module sorted_table_search_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sts_pkg::*;

  localparam int DEPTH      = TABLE_DEPTH_DEF;
  localparam int IDLE_WAIT  = 30;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst;
  logic table_count_valid;
  logic table_count_ready;
  logic [COUNT_BITS-1:0] table_count;
  logic in_valid;
  logic in_stall;
  logic opcode;
  logic [9:0] entry_index;
  logic signed [31:0] entry_value;
  logic signed [31:0] search_value;
  logic [2:0] search_mode;
  logic out_valid;
  logic out_stall;
  logic signed [POS_BITS-1:0] position;
  int errors;
  int pending;

  int quiet_cycles;
  int used;
  int hold_count;
  bit steady_flow;
  bit long_hold;
  logic signed [31:0] table_values [DEPTH];

  sorted_table_search_unit DUT (.*);

  sorted_table_search_unit_check checker_inst (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // steady flow: no idling on either side while the flag is set
  function automatic bit steady();
    return steady_flow;
  endfunction

  // result side: random stalls plus one long hold counted here
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_count <= 0;
    end else if (long_hold && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= !steady() && ($urandom_range(99) < 35);
    end
  end

  // watchdog on accepted requests and results
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (table_count_valid && table_count_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL sorted_table_search_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request, holding it until accepted
  task automatic send_request(logic op, logic [9:0] idx, logic signed [31:0] ev,
                              logic signed [31:0] sv, logic [2:0] mode);
    while (!steady() && $urandom_range(99) < 35) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    opcode = op;
    entry_index = idx;
    entry_value = ev;
    search_value = sv;
    search_mode = mode;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_entry(int idx, logic signed [31:0] v);
    if (idx < used) table_values[idx] = v;
    send_request(OP_WRITE, 10'(idx), v, $urandom, 3'($urandom));
  endtask

  task automatic query(logic signed [31:0] sv, logic [2:0] mode);
    send_request(OP_QUERY, 10'($urandom), $urandom, sv, mode);
  endtask

  // set the entry count once the block has drained
  task automatic set_count(int cnt);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
    table_count = COUNT_BITS'(cnt);
    table_count_valid = 1'b1;
    do @(posedge clk); while (!table_count_ready);
    @(negedge clk);
    table_count_valid = 1'b0;
    used = (cnt > DEPTH) ? DEPTH : cnt;
  endtask

  // ascending contents with duplicates; wide spreads reach both extremes
  task automatic fill_table(bit wide);
    longint v;
    longint step_max;
    step_max = wide ? (64'h1_0000_0000 / (used + 1)) : 4;
    v = wide ? -64'sd2147483648 : longint'($signed(32'($urandom))) / 2;
    for (int i = 0; i < used; i++) begin
      if (wide && i == used - 1) v = 64'sd2147483647;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      write_entry(i, 32'(v));
      if ($urandom_range(3) != 0) v += longint'($urandom_range(0, 32'(step_max)));
    end
  endtask

  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    k = (used > 0) ? table_values[$urandom_range(used - 1)] : $signed($urandom);
    case ($urandom_range(9))
      5: k = k + 1;
      6: k = k - 1;
      7: k = 32'sh8000_0000;
      8: k = 32'sh7fff_ffff;
      9: k = $urandom;
      default: ;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] pick_mode();
    if ($urandom_range(15) > 13) return 3'($urandom_range(5, 7));
    return 3'($urandom_range(MODE_EXACT, MODE_LAST));
  endfunction

  // mixed traffic: mostly queries, some order-keeping rewrites and writes past the count
  task automatic traffic(int n);
    int i;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 85) begin
        query(pick_key(), pick_mode());
      end else if (used < DEPTH && $urandom_range(1)) begin
        write_entry($urandom_range(used, DEPTH - 1), $urandom);
      end else if (used > 1) begin
        i = $urandom_range(used - 2);
        write_entry(i, table_values[i + 1]);
      end
    end
  endtask

  initial begin
    int sent;
    int cnt;
    rst = 1'b1;
    quiet_cycles = 0;
    used = 0;
    steady_flow = 1'b0;
    long_hold = 1'b0;
    table_count_valid = 1'b0;
    table_count = '0;
    in_valid = 1'b0;
    opcode = OP_WRITE;
    entry_index = '0;
    entry_value = '0;
    search_value = '0;
    search_mode = MODE_EXACT;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // empty table: every mode, unknown ones too
    for (int m = 0; m < 8; m++) query(32'sd0, 3'(m));
    // single entry at the low extreme
    set_count(1);
    write_entry(0, 32'sh8000_0000);
    query(32'sh8000_0000, MODE_EXACT);
    query(32'sh8000_0000, MODE_LAST);
    query(32'sh7fff_ffff, MODE_LOWER);
    // small table spanning the full value range
    set_count(5);
    fill_table(1'b1);
    query(32'sh7fff_ffff, MODE_FIRST);
    query(32'sh7fff_ffff, MODE_UPPER);
    query(32'sh8000_0000, MODE_LOWER);
    query(32'sh8000_0000, MODE_UPPER);
    query(32'sh8000_0001, MODE_EXACT);
    write_entry(1023, 32'sh7fff_ffff);
    write_entry(0, 32'sh8000_0000);
    query(32'sh7fff_ffff, MODE_LAST);

    // random phases with mostly small tables
    sent = 0;
    while (sent < 300) begin
      cnt = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 40);
      set_count(cnt);
      fill_table($urandom_range(3) == 0);
      cnt = $urandom_range(40, 90);
      traffic(cnt);
      sent += cnt + used;
    end

    // full table with no idling, then a long hold at the result side
    set_count(DEPTH);
    steady_flow = 1'b1;
    fill_table(1'b1);
    traffic(80);
    steady_flow = 1'b0;
    long_hold = 1'b1;
    traffic(80);
    // count above the depth
    set_count(2047);
    traffic(80);
    set_count(0);
    traffic(10);

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
    if (errors == 0) $display("PASS sorted_table_search_unit");
    else $display("FAIL sorted_table_search_unit");
    $finish;
  end

endmodule

### sorted_table_search_unit.f
src/sts_pkg.sv
src/sts_stage.sv
src/sts_check.sv
src/sorted_table_search_unit.sv
sim/sorted_table_search_unit_check.sv
sim/sorted_table_search_unit_test.sv
